[sv/zrpsd_pkg.sv]
// ----------------------------------------------------------------------------
// Zero-run palette sprite decoder package
// Shared constants, function and register codes, and the run word type.
// ----------------------------------------------------------------------------
package zrpsd_pkg;

    // Default sizes
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    // Input function codes
    localparam logic [1:0] FUNC_PALETTE = 2'd0;
    localparam logic [1:0] FUNC_FRAME   = 2'd1;
    localparam logic [1:0] FUNC_DATA    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RLE_ENABLE    = 1'b0;
    localparam logic CFG_PALETTE_VALID = 1'b1;

    // Alpha values
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // One emitted pixel run
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] run_pixels;
        logic        frame_end;
    } t_run;

endpackage

[sv/zrpsd_run_fifo.sv]
// ----------------------------------------------------------------------------
// Run word queue
// Small output queue that takes up to two run words per cycle and hands out
// one word per cycle over a valid/ready channel.
// ----------------------------------------------------------------------------
module zrpsd_run_fifo #(
    parameter int unsigned DEPTH = zrpsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_count,
    input  zrpsd_pkg::t_run            i_word0,
    input  zrpsd_pkg::t_run            i_word1,
    output logic [$clog2(DEPTH+1)-1:0] o_free,
    output logic                       o_valid,
    input  logic                       i_ready,
    output zrpsd_pkg::t_run            o_word
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    zrpsd_pkg::t_run r_slots [DEPTH];
    logic [PW-1:0]   r_head;
    logic [PW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_head;
    logic [PW-1:0]   n_tail;
    logic [CW-1:0]   n_count;
    logic [PW-1:0]   tail_next;
    logic            pop;

    // Step to the slot after the tail, wrapping after the last slot
    assign tail_next = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_word  = r_slots[r_head];
    assign o_free  = CW'(DEPTH) - r_count;

    // Advance pointers and count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count + CW'(i_push_count) - CW'(pop);
        if (pop) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
        case (i_push_count)
            2'd1:    n_tail = tail_next;
            2'd2:    n_tail = (tail_next == PW'(DEPTH - 1)) ? '0 : tail_next + PW'(1);
            default: n_tail = r_tail;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_slots[r_tail] <= i_word0;
        end
        if (i_push_count == 2'd2) begin
            r_slots[tail_next] <= i_word1;
        end
    end

endmodule

[sv/zero_run_palette_sprite_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Zero-run palette sprite decoder
// Decodes zero-run or raw indexed sprite data into RGBA pixel runs through a
// palette held in a synchronous RAM.
// ----------------------------------------------------------------------------
// The unit takes one input word per cycle unless the run queue lacks room
// for the decode stage's runs: palette writes, frame starts and encoded data
// bytes all sustain one word per clock. A data word reads the palette RAM at
// the edge that accepts it and is decoded in the next cycle by the decode
// stage, which also holds the pixel counter. A word with two runs (a literal
// or zero run plus the frame end run) queues both at once; the single output
// port hands them out one at a time. Results leave through a small run queue,
// so input keeps flowing while a finished run waits. No clearing pass is
// needed after reset; palette entries must be written before they are used.
// ----------------------------------------------------------------------------
module zero_run_palette_sprite_decoder_unit #(
    parameter int unsigned PALETTE_ENTRIES = zrpsd_pkg::PALETTE_ENTRIES_DEF,
    parameter int unsigned QUEUE_DEPTH     = zrpsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_palette_slot,
    input  logic [7:0]  i_entry_red,
    input  logic [7:0]  i_entry_green,
    input  logic [7:0]  i_entry_blue,
    input  logic [15:0] i_frame_width,
    input  logic [15:0] i_frame_height,
    input  logic [7:0]  i_code_byte,
    input  logic        i_block_last,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic [31:0] o_run_pixels,
    output logic        o_frame_end
);

    localparam int unsigned AW  = $clog2(PALETTE_ENTRIES);
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

    // Palette RAM and slot zero shadow
    logic [23:0]     r_palette [PALETTE_ENTRIES];
    logic [23:0]     r_rd_data;
    logic [23:0]     r_entry0;

    // Configuration
    logic            r_rle_enable;
    logic            r_palette_valid;

    // Decode stage
    logic            r_s1_valid;
    logic [1:0]      r_s1_func;
    logic [7:0]      r_s1_byte;
    logic            r_s1_last;
    logic            r_s1_in_range;
    logic [15:0]     r_s1_width;
    logic [15:0]     r_s1_height;

    // Frame state
    logic [31:0]     r_pixels_left;
    logic            r_expect;
    logic [31:0]     n_pixels_left;
    logic            n_expect;

    logic            in_fire;
    logic            slot_in_range;
    logic            code_in_range;
    logic            s1_advance;
    logic            res0_v;
    logic            res1_v;
    zrpsd_pkg::t_run res0;
    zrpsd_pkg::t_run res1;
    logic [1:0]      n_res;
    logic [1:0]      push_count;
    logic [QCW-1:0]  q_free;
    logic [23:0]     clear_rgb;
    logic [23:0]     lit_rgb;
    logic [7:0]      lit_alpha;
    logic [31:0]     run_len;
    logic [31:0]     left_mid;
    zrpsd_pkg::t_run q_word;

    assign in_fire       = i_in_valid && o_in_ready;
    assign slot_in_range = ({1'b0, i_palette_slot} < 9'(PALETTE_ENTRIES));
    assign code_in_range = ({1'b0, i_code_byte} < 9'(PALETTE_ENTRIES));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_enable    <= 1'b1;
            r_palette_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                zrpsd_pkg::CFG_RLE_ENABLE:    r_rle_enable    <= i_cfg_data;
                zrpsd_pkg::CFG_PALETTE_VALID: r_palette_valid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Palette RAM: write on palette words, read on data words
    always_ff @(posedge i_clk) begin
        if (in_fire && i_func == zrpsd_pkg::FUNC_PALETTE && slot_in_range) begin
            r_palette[i_palette_slot[AW-1:0]] <= {i_entry_red, i_entry_green, i_entry_blue};
        end
        if (in_fire && i_func == zrpsd_pkg::FUNC_DATA && code_in_range) begin
            r_rd_data <= r_palette[i_code_byte[AW-1:0]];
        end
    end

    // Keep slot zero in a register for transparent runs
    always_ff @(posedge i_clk) begin
        if (in_fire && i_func == zrpsd_pkg::FUNC_PALETTE && i_palette_slot == 8'd0) begin
            r_entry0 <= {i_entry_red, i_entry_green, i_entry_blue};
        end
    end

    // Load the decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func     <= i_func;
            r_s1_byte     <= i_code_byte;
            r_s1_last     <= i_block_last;
            r_s1_in_range <= code_in_range;
            r_s1_width    <= i_frame_width;
            r_s1_height   <= i_frame_height;
        end
    end

    // Decode one word against the frame state
    always_comb begin
        res0_v        = 1'b0;
        res1_v        = 1'b0;
        res0          = '0;
        res1          = '0;
        n_pixels_left = r_pixels_left;
        n_expect      = r_expect;
        left_mid      = r_pixels_left;
        clear_rgb     = r_palette_valid ? r_entry0 : 24'h0;
        lit_rgb       = (r_palette_valid && r_s1_in_range) ? r_rd_data : 24'h0;
        lit_alpha     = (r_palette_valid && r_s1_in_range && r_s1_byte != 8'd0)
                        ? zrpsd_pkg::ALPHA_OPAQUE : zrpsd_pkg::ALPHA_CLEAR;
        run_len       = ({24'h0, r_s1_byte} < r_pixels_left) ? {24'h0, r_s1_byte}
                        : r_pixels_left;
        case (r_s1_func)
            zrpsd_pkg::FUNC_FRAME: begin
                n_pixels_left = {16'h0, r_s1_width} * {16'h0, r_s1_height};
                n_expect      = 1'b0;
            end
            zrpsd_pkg::FUNC_DATA: begin
                if (r_pixels_left != 32'd0) begin
                    if (r_rle_enable && r_expect) begin
                        // count byte of a zero run
                        n_expect = 1'b0;
                        left_mid = r_pixels_left - run_len;
                        if (run_len != 32'd0) begin
                            res0_v = 1'b1;
                            res0   = {clear_rgb, zrpsd_pkg::ALPHA_CLEAR, run_len, 1'b0};
                        end
                    end else if (r_rle_enable && r_s1_byte == 8'd0) begin
                        n_expect = 1'b1;
                    end else begin
                        // single literal pixel
                        n_expect = 1'b0;
                        left_mid = r_pixels_left - 32'd1;
                        res0_v   = 1'b1;
                        res0     = {lit_rgb, lit_alpha, 32'd1, 1'b0};
                    end
                end
                n_pixels_left = left_mid;
                if (r_s1_last) begin
                    // flush the rest of the frame as one transparent run
                    res1_v        = 1'b1;
                    res1          = {clear_rgb, zrpsd_pkg::ALPHA_CLEAR, left_mid, 1'b1};
                    n_pixels_left = 32'd0;
                    n_expect      = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Advance only when the queue can take every run of this word
    assign n_res      = 2'(res0_v) + 2'(res1_v);
    assign s1_advance = r_s1_valid && (q_free >= QCW'(n_res));
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign push_count = s1_advance ? n_res : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_left <= 32'd0;
            r_expect      <= 1'b0;
        end else if (s1_advance) begin
            r_pixels_left <= n_pixels_left;
            r_expect      <= n_expect;
        end
    end

    zrpsd_run_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_run_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_word0      (res0_v ? res0 : res1),
        .i_word1      (res1),
        .o_free       (q_free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_word       (q_word)
    );

    assign o_out_red    = q_word.red;
    assign o_out_green  = q_word.green;
    assign o_out_blue   = q_word.blue;
    assign o_out_alpha  = q_word.alpha;
    assign o_run_pixels = q_word.run_pixels;
    assign o_frame_end  = q_word.frame_end;

`ifndef SYNTH
    // Frame end leaves no pixels and no pending count
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && res1_v) |=> (r_pixels_left == 32'd0 && !r_expect))
        else $error("frame end did not clear frame state");

    // Only a frame start may raise the pixel count
    a_left_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_func != zrpsd_pkg::FUNC_FRAME)
        |=> (r_pixels_left <= $past(r_pixels_left)))
        else $error("pixel count grew without a frame start");

    // A stalled decode stage keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance)
        |=> (r_s1_valid && $stable(r_s1_func) && $stable(r_s1_byte) && $stable(r_s1_last)))
        else $error("decode stage lost a stalled word");

    // Opaque runs are always single literal pixels
    a_opaque_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_alpha == zrpsd_pkg::ALPHA_OPAQUE)
        |-> (o_run_pixels == 32'd1 && !o_frame_end))
        else $error("opaque run longer than one pixel");
`endif

endmodule
